>>> hdl/srit_pkg.sv
// Shared definitions for the segment/window hit test pipeline.
// Holds the default coordinate width, register index codes and the flag struct.
// Has no dependencies; every other file in this folder imports it.
package srit_pkg;

  // Default coordinate width (Q12.4 signed).
  localparam int unsigned COORD_BITS_DEF = 16;

  // Width of the configuration register index.
  localparam int unsigned REG_IDX_BITS = 3;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_WIN_LEFT   = 3'd0,
    REG_WIN_TOP    = 3'd1,
    REG_WIN_RIGHT  = 3'd2,
    REG_WIN_BOTTOM = 3'd3
  } srit_reg_e;

  // Comparison results that travel beside the arithmetic data.
  typedef struct packed {
    logic in_start;   // start point lies inside the window
    logic in_end;     // end point lies inside the window
    logic str_left;   // x range straddles the left edge
    logic str_right;  // x range straddles the right edge
    logic str_top;    // y range straddles the top edge
    logic str_bottom; // y range straddles the bottom edge
  } srit_flags_t;

endpackage

>>> hdl/srit_diff.sv
// First pipeline stage: direction vector, corner offsets and window compares.
// Depends on srit_pkg for the flag struct and the default width.
module srit_diff #(
  parameter int unsigned COORD_BITS = srit_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] win_left_i,
  input  logic signed [COORD_BITS-1:0] win_top_i,
  input  logic signed [COORD_BITS-1:0] win_right_i,
  input  logic signed [COORD_BITS-1:0] win_bottom_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [COORD_BITS:0]   dx_o,
  output logic signed [COORD_BITS:0]   dy_o,
  output logic signed [COORD_BITS:0]   ox_left_o,
  output logic signed [COORD_BITS:0]   ox_right_o,
  output logic signed [COORD_BITS:0]   oy_top_o,
  output logic signed [COORD_BITS:0]   oy_bottom_o,
  output srit_pkg::srit_flags_t        flags_o
);
  import srit_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;

  logic signed [DW-1:0] sx_w, sy_w, ex_w, ey_w;
  logic signed [DW-1:0] dx_d, dy_d, oxl_d, oxr_d, oyt_d, oyb_d;
  logic signed [DW-1:0] dx_q, dy_q, oxl_q, oxr_q, oyt_q, oyb_q;
  srit_flags_t          flags_d, flags_q;
  logic                 valid_q;

  // Differences are one bit wider than the coordinates, so they are exact.
  always_comb begin
    sx_w  = DW'(start_x_i);
    sy_w  = DW'(start_y_i);
    ex_w  = DW'(end_x_i);
    ey_w  = DW'(end_y_i);
    dx_d  = ex_w - sx_w;
    dy_d  = ey_w - sy_w;
    oxl_d = DW'(win_left_i) - sx_w;
    oxr_d = DW'(win_right_i) - sx_w;
    oyt_d = DW'(win_top_i) - sy_w;
    oyb_d = DW'(win_bottom_i) - sy_w;
  end

  // Half-open inside tests and edge straddle tests.
  always_comb begin
    flags_d.in_start   = (win_left_i <= start_x_i) && (start_x_i < win_right_i) &&
                         (win_top_i <= start_y_i) && (start_y_i < win_bottom_i);
    flags_d.in_end     = (win_left_i <= end_x_i) && (end_x_i < win_right_i) &&
                         (win_top_i <= end_y_i) && (end_y_i < win_bottom_i);
    flags_d.str_left   = (start_x_i < win_left_i) ^ (end_x_i < win_left_i);
    flags_d.str_right  = (start_x_i < win_right_i) ^ (end_x_i < win_right_i);
    flags_d.str_top    = (start_y_i < win_top_i) ^ (end_y_i < win_top_i);
    flags_d.str_bottom = (start_y_i < win_bottom_i) ^ (end_y_i < win_bottom_i);
  end

  // The stage takes a new transaction when it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      oxl_q   <= oxl_d;
      oxr_q   <= oxr_d;
      oyt_q   <= oyt_d;
      oyb_q   <= oyb_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o     = valid_q;
  assign dx_o        = dx_q;
  assign dy_o        = dy_q;
  assign ox_left_o   = oxl_q;
  assign ox_right_o  = oxr_q;
  assign oy_top_o    = oyt_q;
  assign oy_bottom_o = oyb_q;
  assign flags_o     = flags_q;

endmodule

>>> hdl/srit_cross.sv
// Second pipeline stage: the four partial products of the corner cross products.
// Depends on srit_pkg for the flag struct and the default width.
module srit_cross #(
  parameter int unsigned COORD_BITS = srit_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [COORD_BITS:0]       dx_i,
  input  logic signed [COORD_BITS:0]       dy_i,
  input  logic signed [COORD_BITS:0]       ox_left_i,
  input  logic signed [COORD_BITS:0]       ox_right_i,
  input  logic signed [COORD_BITS:0]       oy_top_i,
  input  logic signed [COORD_BITS:0]       oy_bottom_i,
  input  srit_pkg::srit_flags_t            flags_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [2*COORD_BITS+1:0]   p_top_o,
  output logic signed [2*COORD_BITS+1:0]   p_bottom_o,
  output logic signed [2*COORD_BITS+1:0]   q_left_o,
  output logic signed [2*COORD_BITS+1:0]   q_right_o,
  output srit_pkg::srit_flags_t            flags_o
);
  import srit_pkg::*;

  localparam int unsigned PW = 2 * COORD_BITS + 2;

  logic signed [PW-1:0] pt_d, pb_d, ql_d, qr_d;
  logic signed [PW-1:0] pt_q, pb_q, ql_q, qr_q;
  srit_flags_t          flags_q;
  logic                 valid_q;

  // Cross product of corner c is dx*(cy-sy) - dy*(cx-sx); only four products differ.
  always_comb begin
    pt_d = PW'(dx_i) * PW'(oy_top_i);
    pb_d = PW'(dx_i) * PW'(oy_bottom_i);
    ql_d = PW'(dy_i) * PW'(ox_left_i);
    qr_d = PW'(dy_i) * PW'(ox_right_i);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pt_q    <= pt_d;
      pb_q    <= pb_d;
      ql_q    <= ql_d;
      qr_q    <= qr_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o    = valid_q;
  assign p_top_o    = pt_q;
  assign p_bottom_o = pb_q;
  assign q_left_o   = ql_q;
  assign q_right_o  = qr_q;
  assign flags_o    = flags_q;

endmodule

>>> hdl/srit_decide.sv
// Third pipeline stage: corner side signs, hit combination and the output register.
// Depends on srit_pkg for the flag struct and the default width.
module srit_decide #(
  parameter int unsigned COORD_BITS = srit_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [2*COORD_BITS+1:0] p_top_i,
  input  logic signed [2*COORD_BITS+1:0] p_bottom_i,
  input  logic signed [2*COORD_BITS+1:0] q_left_i,
  input  logic signed [2*COORD_BITS+1:0] q_right_i,
  input  srit_pkg::srit_flags_t          flags_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic                           hit_o
);
  import srit_pkg::*;

  logic lt, lb, rt, rb;
  logic hit_d, hit_q;
  logic valid_q;

  // A corner is on the negative side when its cross product is below zero.
  always_comb begin
    lt = p_top_i < q_left_i;
    lb = p_bottom_i < q_left_i;
    rt = p_top_i < q_right_i;
    rb = p_bottom_i < q_right_i;
    hit_d = flags_i.in_start || flags_i.in_end ||
            (flags_i.str_left && (lt ^ lb)) ||
            (flags_i.str_right && (rt ^ rb)) ||
            (flags_i.str_top && (lt ^ rt)) ||
            (flags_i.str_bottom && (lb ^ rb));
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;

`ifndef ASSERT_OFF
  // An endpoint inside the window always produces a hit.
  a_inside_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && (flags_i.in_start || flags_i.in_end) |=> hit_o)
    else $error("endpoint inside window did not give a hit");

  // Without an inside endpoint or any straddle there can be no hit.
  a_no_cause_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && !flags_i.in_start && !flags_i.in_end &&
    !flags_i.str_left && !flags_i.str_right && !flags_i.str_top &&
    !flags_i.str_bottom |=> !hit_o)
    else $error("hit reported without inside point or straddle");
`endif

endmodule

>>> hdl/segment_rect_intersect_test_unit.sv
// Top level of the segment/window hit test: window registers and three-stage pipeline.
// Depends on srit_pkg, srit_diff, srit_cross and srit_decide.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+-------------------------------
//   input    | in        | in_valid_i / in_stall_o     | start_x_i start_y_i end_x_i end_y_i
//   output   | out       | out_valid_o / out_stall_i   | hit_o
//   config   | in        | cfg_we_i                    | cfg_idx_i cfg_data_i
//
// One transaction is taken per cycle while in_stall_o is low; its result passes the difference
// stage, the multiplier stage and the compare stage with its output register, in that order.
// Throughput is one item per cycle while the output does not stall: items share no state.
// Reset clears the pipeline valid bits and sets all window edges to zero.
// A stall at the output fills empty stages first; in_stall_o rises only when all
// three stages hold a transaction and the output is stalled.
module segment_rect_intersect_test_unit #(
  parameter int unsigned COORD_BITS = srit_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_BITS-1:0]        start_x_i,
  input  logic signed [COORD_BITS-1:0]        start_y_i,
  input  logic signed [COORD_BITS-1:0]        end_x_i,
  input  logic signed [COORD_BITS-1:0]        end_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  input  logic                                cfg_we_i,
  input  logic [srit_pkg::REG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [COORD_BITS-1:0]               cfg_data_i
);
  import srit_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] win_left_q, win_top_q, win_right_q, win_bottom_q;

  logic                 s1_ready, s1_valid;
  logic                 s2_ready, s2_valid;
  logic                 s3_ready;
  logic signed [DW-1:0] s1_dx, s1_dy, s1_oxl, s1_oxr, s1_oyt, s1_oyb;
  srit_flags_t          s1_flags, s2_flags;
  logic signed [PW-1:0] s2_pt, s2_pb, s2_ql, s2_qr;

  // Window registers; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= '0;
      win_top_q    <= '0;
      win_right_q  <= '0;
      win_bottom_q <= '0;
    end else if (cfg_we_i) begin
      case (srit_reg_e'(cfg_idx_i))
        REG_WIN_LEFT:   win_left_q   <= cfg_data_i;
        REG_WIN_TOP:    win_top_q    <= cfg_data_i;
        REG_WIN_RIGHT:  win_right_q  <= cfg_data_i;
        REG_WIN_BOTTOM: win_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Difference and compare stage.
  srit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (s1_ready),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .win_left_i   (win_left_q),
    .win_top_i    (win_top_q),
    .win_right_i  (win_right_q),
    .win_bottom_i (win_bottom_q),
    .valid_o      (s1_valid),
    .ready_i      (s2_ready),
    .dx_o         (s1_dx),
    .dy_o         (s1_dy),
    .ox_left_o    (s1_oxl),
    .ox_right_o   (s1_oxr),
    .oy_top_o     (s1_oyt),
    .oy_bottom_o  (s1_oyb),
    .flags_o      (s1_flags)
  );

  // Multiplier stage.
  srit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .ready_o     (s2_ready),
    .dx_i        (s1_dx),
    .dy_i        (s1_dy),
    .ox_left_i   (s1_oxl),
    .ox_right_i  (s1_oxr),
    .oy_top_i    (s1_oyt),
    .oy_bottom_i (s1_oyb),
    .flags_i     (s1_flags),
    .valid_o     (s2_valid),
    .ready_i     (s3_ready),
    .p_top_o     (s2_pt),
    .p_bottom_o  (s2_pb),
    .q_left_o    (s2_ql),
    .q_right_o   (s2_qr),
    .flags_o     (s2_flags)
  );

  // Sign compare stage with the output register.
  srit_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s2_valid),
    .ready_o    (s3_ready),
    .p_top_i    (s2_pt),
    .p_bottom_i (s2_pb),
    .q_left_i   (s2_ql),
    .q_right_i  (s2_qr),
    .flags_i    (s2_flags),
    .valid_o    (out_valid_o),
    .ready_i    (!out_stall_i),
    .hit_o      (hit_o)
  );

  assign in_stall_o = !s1_ready;

`ifndef ASSERT_OFF
  // The input side stalls only when every stage holds a transaction.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && s2_valid && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  // A full pipeline with a free output never stalls the input.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled although the output moves");
`endif

endmodule
